FILE: rtl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// No dependencies; every other file in rtl refers to this package by scoped name.
`default_nettype none

package bdq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SizeW = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [TimeW-1:0] arrival;
    logic [SizeW-1:0] size;
  } entry_t;

  typedef struct packed {
    logic shift_r;
    logic shift_l;
    logic wr_back;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bdq_cell.sv
// One storage cell of the queue row, holding a single entry.
// Depends on bdq_pkg for the entry and command types.
`default_nettype none

module bdq_cell #(
  parameter int unsigned CountW = 5,
  parameter int unsigned Idx    = 0
) (
  input  wire                 clk_i,
  input  bdq_pkg::cmd_t       cmd_i,
  input  wire  [CountW-1:0]   count_i,
  input  bdq_pkg::entry_t     new_i,
  input  bdq_pkg::entry_t     left_i,
  input  bdq_pkg::entry_t     right_i,
  output bdq_pkg::entry_t     data_o
);

  localparam logic [CountW-1:0] CellIdx = CountW'(Idx);

  bdq_pkg::entry_t data_d, data_q;

  always_comb begin
    data_d = data_q;
    priority if (cmd_i.shift_r) begin
      data_d = left_i;
    end else if (cmd_i.shift_l) begin
      data_d = right_i;
    end else if (cmd_i.wr_back && (count_i == CellIdx)) begin
      data_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/bdq_ctrl.sv
// Fill count and operation decode that steer the row of cells.
// Depends on bdq_pkg for the operation codes and the cell command struct.
`default_nettype none

module bdq_ctrl #(
  parameter int unsigned Depth  = bdq_pkg::DefaultDepth,
  parameter int unsigned CountW = $clog2(Depth + 1)
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                fire_i,
  input  wire  [1:0]         kind_i,
  output bdq_pkg::cmd_t      cmd_o,
  output logic [CountW-1:0]  count_o,
  output logic [CountW-1:0]  count_next_o,
  output logic               error_o
);

  localparam logic [CountW-1:0] Full = CountW'(Depth);
  localparam logic [CountW-1:0] One  = CountW'(1);

  logic [CountW-1:0] count_d, count_q;
  logic              full, empty;

  assign full  = (count_q == Full);
  assign empty = (count_q == '0);

  always_comb begin
    cmd_o   = '0;
    error_o = 1'b0;
    count_d = count_q;
    unique case (bdq_pkg::kind_e'(kind_i))
      bdq_pkg::KIND_PUSH_FRONT: begin
        error_o       = full;
        cmd_o.shift_r = fire_i && !full;
        if (fire_i && !full) count_d = count_q + One;
      end
      bdq_pkg::KIND_PUSH_BACK: begin
        error_o       = full;
        cmd_o.wr_back = fire_i && !full;
        if (fire_i && !full) count_d = count_q + One;
      end
      bdq_pkg::KIND_POP_FRONT: begin
        error_o       = empty;
        cmd_o.shift_l = fire_i && !empty;
        if (fire_i && !empty) count_d = count_q - One;
      end
      bdq_pkg::KIND_POP_BACK: begin
        error_o = empty;
        if (fire_i && !empty) count_d = count_q - One;
      end
      default: begin
        error_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

`default_nettype wire

FILE: rtl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: control, the row of cells, result register.
// Depends on bdq_pkg, bdq_ctrl and bdq_cell.
`default_nettype none

// The queue holds up to Depth entries in a row of cells, the front entry always in the
// first cell. A push at the front shifts the whole row one cell back, a pop at the front
// shifts it one cell forward, and a push at the back writes the cell that the fill count
// names, so one word is taken per clock while the output register is free or being read.
// Each accepted word yields one result word in the output register; a new word is taken
// while no result waits or in the same cycle as the waiting result is taken. A push to a
// full queue or a pop from an empty one raises the error flag and leaves the contents unchanged.
module bounded_double_ended_queue #(
  parameter int unsigned Depth = bdq_pkg::DefaultDepth
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [1:0]                 kind_i,
  input  wire  [bdq_pkg::TimeW-1:0]  arrival_time_i,
  input  wire  [bdq_pkg::SizeW-1:0]  file_size_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [bdq_pkg::TimeW-1:0]  front_arrival_o,
  output logic                       is_empty_o,
  output logic                       op_error_o
);

  localparam int unsigned CountW = $clog2(Depth + 1);

  logic                      fire;
  bdq_pkg::cmd_t             cmd;
  logic [CountW-1:0]         count;
  logic [CountW-1:0]         count_next;
  logic                      error;
  bdq_pkg::entry_t           new_entry;
  bdq_pkg::entry_t           cell_q [Depth];
  logic [bdq_pkg::TimeW-1:0] front_d;

  logic                      out_valid_d, out_valid_q;
  logic [bdq_pkg::TimeW-1:0] front_q;
  logic                      empty_q, error_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign new_entry.arrival = arrival_time_i;
  assign new_entry.size    = file_size_i;

  bdq_ctrl #(
    .Depth  (Depth),
    .CountW (CountW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .kind_i       (kind_i),
    .cmd_o        (cmd),
    .count_o      (count),
    .count_next_o (count_next),
    .error_o      (error)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    bdq_pkg::entry_t left, right;
    if (i == 0) begin : g_first
      assign left = new_entry;
    end else begin : g_mid
      assign left = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner
      assign right = cell_q[i+1];
    end
    bdq_cell #(
      .CountW (CountW),
      .Idx    (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count),
      .new_i   (new_entry),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_q[i])
    );
  end

  always_comb begin
    priority if (cmd.shift_r) begin
      front_d = arrival_time_i;
    end else if (cmd.shift_l) begin
      front_d = cell_q[1].arrival;
    end else if (cmd.wr_back && (count == '0)) begin
      front_d = arrival_time_i;
    end else begin
      front_d = cell_q[0].arrival;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      front_q <= (count_next == '0) ? '0 : front_d;
      empty_q <= (count_next == '0);
      error_q <= error;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign front_arrival_o = front_q;
  assign is_empty_o      = empty_q;
  assign op_error_o      = error_q;

endmodule

`default_nettype wire

FILE: sim/bounded_double_ended_queue_tb.sv
// Self-checking testbench for bounded_double_ended_queue: a directed table, then random
// push and pop words, each result compared with the table's expected status or a behavioral deque kept here.
// Depends on bdq_pkg and the RTL top level.
`timescale 1ns / 100ps

module bounded_double_ended_queue_tb;

  localparam int unsigned QDepth = bdq_pkg::DefaultDepth;
  localparam int unsigned RandomWords = 1500;
  localparam int unsigned IdleLimit = 2000;

  typedef struct packed {
    logic [bdq_pkg::TimeW-1:0] front;
    logic                      empty;
    logic                      err;
  } deque_status_t;

  typedef struct packed {
    bdq_pkg::kind_e            kind;
    logic [bdq_pkg::TimeW-1:0] arrival;
    logic [bdq_pkg::SizeW-1:0] size;
    logic                      fixed;
    deque_status_t             status;
  } row_t;

  localparam row_t DirectedRows [24] = '{
    '{bdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
    '{bdq_pkg::KIND_POP_BACK,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{bdq_pkg::KIND_PUSH_BACK,  32'h0000_0000, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{bdq_pkg::KIND_POP_FRONT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{bdq_pkg::KIND_POP_BACK,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{bdq_pkg::KIND_PUSH_BACK,  32'h0000_0001, 32'hFFFF_FFFE, 1'b1, '{32'h0000_0001, 1'b0, 1'b0}},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h00FF_00FF, 32'hFF00_FF00, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'hFF00_FF00, 32'h00FF_00FF, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h1234_5678, 32'hEDCB_A987, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'h8765_4321, 32'h789A_BCDE, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'h3C3C_3C3C, 32'hC3C3_C3C3, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'hC3C3_C3C3, 32'h3C3C_3C3C, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'h6969_9696, 32'h9696_6969, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{bdq_pkg::KIND_PUSH_BACK,  32'h1111_1111, 32'h2222_2222, 1'b1, '{32'h8000_0000, 1'b0, 1'b1}},
    '{bdq_pkg::KIND_PUSH_FRONT, 32'h3333_3333, 32'h4444_4444, 1'b1, '{32'h8000_0000, 1'b0, 1'b1}}
  };

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  bdq_pkg::kind_e            kind = bdq_pkg::KIND_PUSH_FRONT;
  logic [bdq_pkg::TimeW-1:0] arrival_time = '0;
  logic [bdq_pkg::SizeW-1:0] file_size = '0;
  logic                      row_fixed = 1'b0;
  deque_status_t             row_status = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [bdq_pkg::TimeW-1:0] front_arrival;
  logic                      is_empty;
  logic                      op_error;

  logic [bdq_pkg::TimeW-1:0] model_arrival [QDepth];
  int unsigned               model_head = 0;
  int unsigned               model_count = 0;
  deque_status_t             deque_status_q [$];
  int unsigned               mismatch_count = 0;
  int unsigned               idle_cycles = 0;
  int unsigned               burst_left = 0;
  int unsigned               rx_mode = 0;
  int unsigned               rx_left = 0;

  bounded_double_ended_queue #(
    .Depth(QDepth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .arrival_time_i (arrival_time),
    .file_size_i    (file_size),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .front_arrival_o(front_arrival),
    .is_empty_o     (is_empty),
    .op_error_o     (op_error)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // File sizes are stored by the block but never reported, so only arrivals are kept here.
  function automatic deque_status_t deque_apply(bdq_pkg::kind_e k,
                                                logic [bdq_pkg::TimeW-1:0] arr);
    deque_status_t s;
    s.err = 1'b0;
    if (k == bdq_pkg::KIND_PUSH_FRONT || k == bdq_pkg::KIND_PUSH_BACK) begin
      if (model_count == QDepth) begin
        s.err = 1'b1;
      end else begin
        if (k == bdq_pkg::KIND_PUSH_FRONT) begin
          model_head = (model_head + QDepth - 1) % QDepth;
          model_arrival[model_head] = arr;
        end else begin
          model_arrival[(model_head + model_count) % QDepth] = arr;
        end
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        s.err = 1'b1;
      end else begin
        if (k == bdq_pkg::KIND_POP_FRONT) begin
          model_head = (model_head + 1) % QDepth;
        end
        model_count--;
      end
    end
    s.empty = (model_count == 0);
    s.front = s.empty ? '0 : model_arrival[model_head];
    return s;
  endfunction

  task automatic send_word(bdq_pkg::kind_e k, logic [bdq_pkg::TimeW-1:0] arr,
                           logic [bdq_pkg::SizeW-1:0] sz, logic fixed,
                           deque_status_t status);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid     <= 1'b1;
    kind         <= k;
    arrival_time <= arr;
    file_size    <= sz;
    row_fixed    <= fixed;
    row_status   <= status;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (deque_status_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(1, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    deque_status_t want;
    deque_status_t pred;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        pred = deque_apply(kind, arrival_time);
        deque_status_q.push_back(row_fixed ? row_status : pred);
      end
      if (out_valid && out_ready) begin
        if (deque_status_q.size() == 0) begin
          $display("%0t: unexpected result word: front_arrival %h is_empty %b op_error %b",
                   $time, front_arrival, is_empty, op_error);
          mismatch_count++;
        end else begin
          want = deque_status_q.pop_front();
          if (front_arrival !== want.front) begin
            $display("%0t: front_arrival expected %h, got %h", $time, want.front, front_arrival);
            mismatch_count++;
          end
          if (is_empty !== want.empty) begin
            $display("%0t: is_empty expected %b, got %b", $time, want.empty, is_empty);
            mismatch_count++;
          end
          if (op_error !== want.err) begin
            $display("%0t: op_error expected %b, got %b", $time, want.err, op_error);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned               random_sent;
    int unsigned               seg_mode;
    int unsigned               seg_len;
    int unsigned               push_pct;
    bdq_pkg::kind_e            k;
    logic [bdq_pkg::TimeW-1:0] arr;

    random_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      send_word(DirectedRows[i].kind, DirectedRows[i].arrival, DirectedRows[i].size,
                DirectedRows[i].fixed, DirectedRows[i].status);
    end
    hold_until_drained();

    // Segments lean toward filling, draining or churning so the deque often meets
    // both its full and its empty boundary.
    while (random_sent < RandomWords) begin
      seg_mode = $urandom_range(0, 2);
      seg_len  = $urandom_range(8, 60);
      push_pct = (seg_mode == 0) ? 85 : (seg_mode == 1) ? 15 : 50;
      if ($urandom_range(0, 9) == 0) begin
        hold_until_drained();
      end
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          k = $urandom_range(0, 1) ? bdq_pkg::KIND_PUSH_BACK : bdq_pkg::KIND_PUSH_FRONT;
        end else begin
          k = $urandom_range(0, 1) ? bdq_pkg::KIND_POP_BACK : bdq_pkg::KIND_POP_FRONT;
        end
        case ($urandom_range(0, 7))
          0: arr = '0;
          1: arr = '1;
          default: arr = $urandom;
        endcase
        send_word(k, arr, $urandom, 1'b0, '0);
        random_sent++;
      end
    end

    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
